@@ rtl/mbia_pkg.sv @@
// Shared types and constants for the mirrored bus core: operation codes,
// microcode word layout, the microprogram ROM and the dispatch table.
// No dependencies; the sequencer, datapath and top level import this package.
package mbia_pkg;

  localparam int ADDR_W = 16;
  localparam int MEM_DEPTH = 65536;
  localparam int UPC_W = 5;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    OP_RD   = 4'd0,
    OP_WR   = 4'd1,
    OP_RD16 = 4'd2,
    OP_WR16 = 4'd3,
    OP_ADD  = 4'd4,
    OP_ZP   = 4'd5,
    OP_ZPX  = 4'd6,
    OP_ABS  = 4'd7,
    OP_ABSX = 4'd8,
    OP_INDX = 4'd9,
    OP_INDY = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    MEM_NONE = 2'd0,
    MEM_RD   = 2'd1,
    MEM_WR   = 2'd2
  } mem_t;

  // Address sources. RD and RDOFF place the byte just read in page zero.
  typedef enum logic [2:0] {
    AS_BUS   = 3'd0,
    AS_BUS1  = 3'd1,
    AS_RD    = 3'd2,
    AS_RDOFF = 3'd3,
    AS_PTR1  = 3'd4,
    AS_HALF  = 3'd5,
    AS_IDX   = 3'd6
  } asrc_t;

  typedef enum logic [1:0] {
    WD_LO  = 2'd0,
    WD_HI  = 2'd1,
    WD_SUM = 2'd2
  } wsrc_t;

  typedef enum logic [1:0] {
    RS_ZERO = 2'd0,
    RS_BYTE = 2'd1,
    RS_HALF = 2'd2,
    RS_SUM  = 2'd3
  } rsel_t;

  typedef enum logic [1:0] {
    SQ_NEXT = 2'd0,
    SQ_JUMP = 2'd1,
    SQ_END  = 2'd2
  } seq_t;

  typedef struct packed {
    mem_t  mem;
    asrc_t asrc;
    wsrc_t wsrc;
    rsel_t rsel;
    logic  ld_lo;
    logic  ld_ptr;
    logic  upd_page;
    seq_t  seq;
    upc_t  target;
  } uword_t;

  // Microprogram entry points and shared tails.
  localparam upc_t UA_RD     = upc_t'(0);
  localparam upc_t UA_WR     = upc_t'(1);
  localparam upc_t UA_WR16   = upc_t'(2);
  localparam upc_t UA_RD16   = upc_t'(4);
  localparam upc_t UA_ADD    = upc_t'(7);
  localparam upc_t UA_ZP     = upc_t'(9);
  localparam upc_t UA_ZPX    = upc_t'(11);
  localparam upc_t UA_ABS    = upc_t'(13);
  localparam upc_t UA_ABSX   = upc_t'(16);
  localparam upc_t UA_INDX   = upc_t'(19);
  localparam upc_t UA_INDY   = upc_t'(23);
  localparam upc_t UA_T_BYTE = upc_t'(27);
  localparam upc_t UA_NOP    = upc_t'(28);
  localparam upc_t UA_LAST   = upc_t'(28);

  function automatic uword_t mw(mem_t m, asrc_t a, wsrc_t w, rsel_t r, logic lo,
                                logic pt, logic pg, seq_t s, upc_t t);
    uword_t u;
    u.mem      = m;
    u.asrc     = a;
    u.wsrc     = w;
    u.rsel     = r;
    u.ld_lo    = lo;
    u.ld_ptr   = pt;
    u.upd_page = pg;
    u.seq      = s;
    u.target   = t;
    return u;
  endfunction

  // One control word per step. A read issued in one step delivers its byte
  // in the next step, where it can be loaded or used as an address.
  function automatic uword_t ucode_rom(upc_t a);
    uword_t u;
    unique case (a)
      upc_t'(0):  u = mw(MEM_RD,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_JUMP, UA_T_BYTE);
      upc_t'(1):  u = mw(MEM_WR,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_END,  UA_NOP);
      upc_t'(2):  u = mw(MEM_WR,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(3):  u = mw(MEM_WR,   AS_BUS1,  WD_HI,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_END,  UA_NOP);
      upc_t'(4):  u = mw(MEM_RD,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(5):  u = mw(MEM_RD,   AS_BUS1,  WD_LO,  RS_ZERO, 1'b1, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(6):  u = mw(MEM_NONE, AS_BUS,   WD_LO,  RS_HALF, 1'b0, 1'b0, 1'b0, SQ_END,  UA_NOP);
      upc_t'(7):  u = mw(MEM_RD,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(8):  u = mw(MEM_WR,   AS_BUS,   WD_SUM, RS_SUM,  1'b0, 1'b0, 1'b0, SQ_END,  UA_NOP);
      upc_t'(9):  u = mw(MEM_RD,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(10): u = mw(MEM_RD,   AS_RD,    WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_JUMP, UA_T_BYTE);
      upc_t'(11): u = mw(MEM_RD,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(12): u = mw(MEM_RD,   AS_RDOFF, WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_JUMP, UA_T_BYTE);
      upc_t'(13): u = mw(MEM_RD,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(14): u = mw(MEM_RD,   AS_BUS1,  WD_LO,  RS_ZERO, 1'b1, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(15): u = mw(MEM_RD,   AS_HALF,  WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_JUMP, UA_T_BYTE);
      upc_t'(16): u = mw(MEM_RD,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(17): u = mw(MEM_RD,   AS_BUS1,  WD_LO,  RS_ZERO, 1'b1, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(18): u = mw(MEM_RD,   AS_IDX,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b1, SQ_JUMP, UA_T_BYTE);
      upc_t'(19): u = mw(MEM_RD,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(20): u = mw(MEM_RD,   AS_RDOFF, WD_LO,  RS_ZERO, 1'b0, 1'b1, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(21): u = mw(MEM_RD,   AS_PTR1,  WD_LO,  RS_ZERO, 1'b1, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(22): u = mw(MEM_RD,   AS_HALF,  WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_JUMP, UA_T_BYTE);
      upc_t'(23): u = mw(MEM_RD,   AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(24): u = mw(MEM_RD,   AS_RD,    WD_LO,  RS_ZERO, 1'b0, 1'b1, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(25): u = mw(MEM_RD,   AS_PTR1,  WD_LO,  RS_ZERO, 1'b1, 1'b0, 1'b0, SQ_NEXT, UA_NOP);
      upc_t'(26): u = mw(MEM_RD,   AS_IDX,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b1, SQ_JUMP, UA_T_BYTE);
      upc_t'(27): u = mw(MEM_NONE, AS_BUS,   WD_LO,  RS_BYTE, 1'b0, 1'b0, 1'b0, SQ_END,  UA_NOP);
      default:    u = mw(MEM_NONE, AS_BUS,   WD_LO,  RS_ZERO, 1'b0, 1'b0, 1'b0, SQ_END,  UA_NOP);
    endcase
    return u;
  endfunction

  function automatic upc_t entry(logic [3:0] op);
    upc_t e;
    unique case (op)
      OP_RD:   e = UA_RD;
      OP_WR:   e = UA_WR;
      OP_RD16: e = UA_RD16;
      OP_WR16: e = UA_WR16;
      OP_ADD:  e = UA_ADD;
      OP_ZP:   e = UA_ZP;
      OP_ZPX:  e = UA_ZPX;
      OP_ABS:  e = UA_ABS;
      OP_ABSX: e = UA_ABSX;
      OP_INDX: e = UA_INDX;
      OP_INDY: e = UA_INDY;
      default: e = UA_NOP;
    endcase
    return e;
  endfunction

endpackage

@@ rtl/mbia_if.sv @@
// Valid/ready channel interfaces for the request and result words.
// Depends on nothing; the top level of the block uses both.
interface mbia_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [15:0] bus_address;
  logic [15:0] write_data;
  logic [7:0]  index_offset;

  modport source (output valid, output op, output bus_address, output write_data,
                  output index_offset, input ready);
  modport sink (input valid, input op, input bus_address, input write_data,
                input index_offset, output ready);
endinterface

interface mbia_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        page_crossed;

  modport source (output valid, output read_data, output page_crossed, input ready);
  modport sink (input valid, input read_data, input page_crossed, output ready);
endinterface

@@ rtl/mbia_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module mbia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mbia_seq.sv @@
// Microcode sequencer: step counter, control ROM lookup and jumps.
// Depends on mbia_pkg for the control word layout and the microprogram.
module mbia_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [3:0]      start_op,
  input  logic            out_free,
  output mbia_pkg::uword_t uw,
  output logic            fire,
  output logic            busy
);
  import mbia_pkg::*;

  logic busy_r, busy_nxt;
  upc_t upc_r, upc_nxt;

  assign uw   = ucode_rom(upc_r);
  // A final step waits until the result register can take the word.
  assign fire = busy_r && ((uw.seq != SQ_END) || out_free);
  assign busy = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = entry(start_op);
    end else if (fire) begin
      unique case (uw.seq)
        SQ_NEXT: upc_nxt = upc_t'(upc_r + 1'b1);
        SQ_JUMP: upc_nxt = uw.target;
        SQ_END:  busy_nxt = 1'b0;
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UA_NOP;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("new word started while sequencer busy");
  a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && uw.seq == SQ_END && !start) |=> !busy_r)
    else $error("sequencer still busy after final step");
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (upc_r <= UA_LAST)) else $error("step counter outside microprogram");

endmodule

@@ rtl/mbia_dp.sv @@
// Datapath: operand registers, address selection, mirror decoding, the byte
// store with its clearing pass, page flag and result register.
// Depends on mbia_pkg and mbia_ram.
module mbia_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [15:0]      bus_address,
  input  logic [15:0]      write_data,
  input  logic [7:0]       index_offset,
  input  mbia_pkg::uword_t uw,
  input  logic             fire,
  input  logic             out_ready,
  output logic             out_free,
  output logic             clr_busy,
  output logic             out_valid,
  output logic [15:0]      out_data,
  output logic             out_page
);
  import mbia_pkg::*;

  logic [15:0] addr_r, data_r;
  logic [7:0]  off_r, lo_r, ptr_r;
  logic        page_r, page_nxt;
  logic        clr_busy_r;
  logic [15:0] clr_addr_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_page_r;

  logic [7:0]  rd_q;
  logic [15:0] half, idx, mem_addr, fold_a;
  logic [7:0]  rdoff, sum, wbyte;
  logic [15:0] res;
  logic        ram_we, ram_re;
  logic [15:0] ram_waddr;
  logic [7:0]  ram_wdata;

  // 0x0800-0x1FFF folds into the first 2 KiB, 0x2000-0x3FFF into 8 registers.
  function automatic logic [15:0] fold(logic [15:0] a);
    logic [15:0] f;
    if (a[15:13] == 3'b000 && a[12:11] != 2'b00) begin
      f = {5'd0, a[10:0]};
    end else if (a[15:13] == 3'b001) begin
      f = {13'h0400, a[2:0]};
    end else begin
      f = a;
    end
    return f;
  endfunction

  assign half  = {rd_q, lo_r};
  assign idx   = half + {8'h00, off_r};
  assign rdoff = rd_q + off_r;
  assign sum   = rd_q + data_r[7:0];

  always_comb begin
    case (uw.asrc)
      AS_BUS:   mem_addr = addr_r;
      AS_BUS1:  mem_addr = addr_r + 16'd1;
      AS_RD:    mem_addr = {8'h00, rd_q};
      AS_RDOFF: mem_addr = {8'h00, rdoff};
      AS_PTR1:  mem_addr = {8'h00, ptr_r + 8'd1};
      AS_HALF:  mem_addr = half;
      AS_IDX:   mem_addr = idx;
      default:  mem_addr = addr_r;
    endcase
    case (uw.wsrc)
      WD_LO:   wbyte = data_r[7:0];
      WD_HI:   wbyte = data_r[15:8];
      WD_SUM:  wbyte = sum;
      default: wbyte = data_r[7:0];
    endcase
    case (uw.rsel)
      RS_ZERO: res = 16'd0;
      RS_BYTE: res = {8'h00, rd_q};
      RS_HALF: res = half;
      RS_SUM:  res = {8'h00, sum};
      default: res = 16'd0;
    endcase
  end

  assign fold_a    = fold(mem_addr);
  assign ram_we    = clr_busy_r || (fire && uw.mem == MEM_WR);
  assign ram_waddr = clr_busy_r ? clr_addr_r : fold_a;
  assign ram_wdata = clr_busy_r ? 8'h00 : wbyte;
  assign ram_re    = fire && uw.mem == MEM_RD;

  mbia_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (fold_a),
    .rdata (rd_q)
  );

  assign page_nxt = (fire && uw.upd_page) ? (half[15:8] != idx[15:8]) : page_r;

  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= bus_address;
      data_r <= write_data;
      off_r  <= index_offset;
    end
    if (fire && uw.ld_lo) begin
      lo_r <= rd_q;
    end
    if (fire && uw.ld_ptr) begin
      ptr_r <= mem_addr[7:0];
    end
    if (fire && uw.seq == SQ_END) begin
      out_data_r <= res;
      out_page_r <= page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r      <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      page_r <= page_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 16'd1;
        if (clr_addr_r == 16'hFFFF) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (fire && uw.seq == SQ_END) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign clr_busy  = clr_busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_page  = out_page_r;

  a_no_step_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !fire) else $error("microstep executed during clearing pass");
  a_page_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && uw.upd_page) |=> $stable(page_r)) else $error("page flag changed unexpectedly");
  a_end_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && uw.seq == SQ_END) |-> out_free) else $error("result register overwritten");

endmodule

@@ rtl/mirrored_bus_with_indirect_addressing_core.sv @@
// Each word runs through its microprogram in the sequencer after the accept cycle; reads
// that depend on earlier reads go one after another through the single read port of the
// byte store, and the result register is loaded by the last step, which waits until the
// result register can take the word. A new word is accepted only while the sequencer is idle.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the store, one byte
// a cycle, during which in_bus.ready stays low.
module mirrored_bus_with_indirect_addressing_core (
  input  logic              clk,
  input  logic              rst_n,
  mbia_in_if.sink           in_bus,
  mbia_out_if.source        out_bus
);
  import mbia_pkg::*;

  uword_t uw;
  logic   fire, busy, start, out_free, clr_busy;

  assign in_bus.ready = !busy && !clr_busy;
  assign start        = in_bus.valid && in_bus.ready;

  mbia_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .start_op (in_bus.op),
    .out_free (out_free),
    .uw       (uw),
    .fire     (fire),
    .busy     (busy)
  );

  mbia_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .bus_address  (in_bus.bus_address),
    .write_data   (in_bus.write_data),
    .index_offset (in_bus.index_offset),
    .uw           (uw),
    .fire         (fire),
    .out_ready    (out_bus.ready),
    .out_free     (out_free),
    .clr_busy     (clr_busy),
    .out_valid    (out_bus.valid),
    .out_data     (out_bus.read_data),
    .out_page     (out_bus.page_crossed)
  );

endmodule
